@@ sv/dqf_pkg.sv @@
package dqf_pkg;

  localparam logic [2:0] FMT_U8  = 3'd0;
  localparam logic [2:0] FMT_I8  = 3'd1;
  localparam logic [2:0] FMT_I16 = 3'd2;
  localparam logic [2:0] FMT_F16 = 3'd3;
  localparam logic [2:0] FMT_F32 = 3'd4;

  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_SCALE  = 2'd1;
  localparam logic [1:0] REG_ZP     = 2'd2;
  localparam logic [1:0] REG_FRAC   = 2'd3;

  localparam logic [31:0] SCALE_RESET = 32'h3F80_0000;
  localparam logic [31:0] QNAN        = 32'h7FC0_0000;

  typedef struct packed {
    logic              valid;
    logic              last;
    logic              err;
    logic              spec;
    logic [31:0]       spec_val;
    logic              sign;
    logic              zero;
    logic [31:0]       prod;
    logic [31:0]       norm;
    logic signed [9:0] e;
    logic [4:0]        k;
  } s3_t;

endpackage

@@ sv/dequantize_to_float32.sv @@
// Path: the start transfer passes through s1v_r, s2v_r, s3_r.valid and valid_r to the out_valid strobe.
// Throughput: one element per cycle; busy stays low, the pipeline never stalls.
// Stages: decode, 24x16 multiply, leading-one search, round and pack.
// Reset: synchronous, active low; clears stage valids and sets config registers to FMT_U8, scale 1.0, zp 0, frac 0.
// The receiver cannot stall; each result shows for exactly one cycle.
module dequantize_to_float32 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_raw_word,
  input  logic        in_last_in,
  output logic        out_valid,
  output logic [31:0] out_value_bits,
  output logic        out_format_error,
  output logic        out_last_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [2:0]  fmt_r;
  logic [31:0] scale_r;
  logic [7:0]  zp_r;
  logic [5:0]  frac_r;

  logic              s1v_nxt, s1s_nxt, s1e_nxt, s1sign_nxt;
  logic [31:0]       s1sv_nxt;
  logic [23:0]       opa_nxt;
  logic [15:0]       opb_nxt;
  logic signed [9:0] exp_nxt;
  logic [8:0]        d;
  logic [8:0]        dmag;
  logic [16:0]       v;
  logic [16:0]       vmag;
  logic [7:0]        ex;
  logic [22:0]       fr;
  logic [31:0]       hb;

  logic              s1v_r, s1l_r, s1s_r, s1e_r, s1sign_r;
  logic [31:0]       s1sv_r;
  logic [23:0]       opa_r;
  logic [15:0]       opb_r;
  logic signed [9:0] exp_r;

  logic              s2v_r, s2l_r, s2s_r, s2e_r, s2sign_r;
  logic [31:0]       s2sv_r;
  logic [31:0]       prod_r;
  logic signed [9:0] exp2_r;
  logic [39:0]       prod_full;

  logic [4:0]        n;
  dqf_pkg::s3_t      s3_nxt;
  dqf_pkg::s3_t      s3_r;
  logic signed [9:0] kk;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r   <= dqf_pkg::FMT_U8;
      scale_r <= dqf_pkg::SCALE_RESET;
      zp_r    <= 8'd0;
      frac_r  <= 6'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dqf_pkg::REG_FORMAT: fmt_r   <= cfg_data[2:0];
        dqf_pkg::REG_SCALE:  scale_r <= cfg_data;
        dqf_pkg::REG_ZP:     zp_r    <= cfg_data[7:0];
        dqf_pkg::REG_FRAC:   frac_r  <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    s1v_nxt    = start && !busy;
    s1s_nxt    = 1'b0;
    s1e_nxt    = 1'b0;
    s1sign_nxt = 1'b0;
    s1sv_nxt   = 32'd0;
    opa_nxt    = 24'd1;
    opb_nxt    = 16'd0;
    exp_nxt    = -{{4{frac_r[5]}}, frac_r};
    ex         = scale_r[30:23];
    fr         = scale_r[22:0];
    d          = {1'b0, in_raw_word[7:0]} - {1'b0, zp_r};
    dmag       = d[8] ? -d : d;
    v          = (fmt_r == dqf_pkg::FMT_I8) ? {{9{in_raw_word[7]}}, in_raw_word[7:0]}
                                            : {in_raw_word[15], in_raw_word[15:0]};
    vmag       = v[16] ? -v : v;
    hb         = ({17'd0, in_raw_word[14:0]} << 13) + 32'h3800_0000;
    case (fmt_r)
      dqf_pkg::FMT_U8: begin
        s1sign_nxt = d[8] ^ scale_r[31];
        opb_nxt    = {8'd0, dmag[7:0]};
        if (ex == 8'hFF) begin
          s1s_nxt = 1'b1;
          if (fr != 23'd0) begin
            s1sv_nxt = scale_r | 32'h0040_0000;
          end else if (dmag == 9'd0) begin
            s1sv_nxt = dqf_pkg::QNAN;
          end else begin
            s1sv_nxt = {s1sign_nxt, 8'hFF, 23'd0};
          end
        end
        if (ex == 8'd0) begin
          opa_nxt = {1'b0, fr};
          exp_nxt = 10'sd1 - 10'sd150;
        end else begin
          opa_nxt = {1'b1, fr};
          exp_nxt = $signed({2'b00, ex}) - 10'sd150;
        end
      end
      dqf_pkg::FMT_I8, dqf_pkg::FMT_I16: begin
        s1sign_nxt = v[16];
        opb_nxt    = vmag[15:0];
      end
      dqf_pkg::FMT_F16: begin
        s1s_nxt  = 1'b1;
        s1sv_nxt = ((in_raw_word[14:10] == 5'd0) ? 32'd0 : hb)
                   | {in_raw_word[15], 31'd0};
      end
      dqf_pkg::FMT_F32: begin
        s1s_nxt  = 1'b1;
        s1sv_nxt = in_raw_word;
      end
      default: begin
        s1s_nxt = 1'b1;
        s1e_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1v_r <= 1'b0;
      s2v_r <= 1'b0;
    end else begin
      s1v_r <= s1v_nxt;
      s2v_r <= s1v_r;
    end
    s1l_r    <= in_last_in;
    s1s_r    <= s1s_nxt;
    s1e_r    <= s1e_nxt;
    s1sign_r <= s1sign_nxt;
    s1sv_r   <= s1sv_nxt;
    opa_r    <= opa_nxt;
    opb_r    <= opb_nxt;
    exp_r    <= exp_nxt;
    s2l_r    <= s1l_r;
    s2s_r    <= s1s_r;
    s2e_r    <= s1e_r;
    s2sign_r <= s1sign_r;
    s2sv_r   <= s1sv_r;
    prod_r   <= prod_full[31:0];
    exp2_r   <= exp_r;
  end

  assign prod_full = opa_r * opb_r;

  always_comb begin
    n = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (prod_r[i]) n = i[4:0];
    end
    kk              = exp2_r + 10'sd149;
    s3_nxt.valid    = s2v_r;
    s3_nxt.last     = s2l_r;
    s3_nxt.err      = s2e_r;
    s3_nxt.spec     = s2s_r;
    s3_nxt.spec_val = s2sv_r;
    s3_nxt.sign     = s2sign_r;
    s3_nxt.zero     = (prod_r == 32'd0);
    s3_nxt.prod     = prod_r;
    s3_nxt.norm     = prod_r << (5'd31 - n);
    s3_nxt.e        = $signed({5'd0, n}) + exp2_r + 10'sd127;
    s3_nxt.k        = kk[4:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_r.valid <= 1'b0;
    end else begin
      s3_r.valid <= s3_nxt.valid;
    end
    s3_r.last     <= s3_nxt.last;
    s3_r.err      <= s3_nxt.err;
    s3_r.spec     <= s3_nxt.spec;
    s3_r.spec_val <= s3_nxt.spec_val;
    s3_r.sign     <= s3_nxt.sign;
    s3_r.zero     <= s3_nxt.zero;
    s3_r.prod     <= s3_nxt.prod;
    s3_r.norm     <= s3_nxt.norm;
    s3_r.e        <= s3_nxt.e;
    s3_r.k        <= s3_nxt.k;
  end

  dqf_pack u_pack (
    .clk              (clk),
    .rst_n            (rst_n),
    .s3_r             (s3_r),
    .out_valid        (out_valid),
    .out_value_bits   (out_value_bits),
    .out_format_error (out_format_error),
    .out_last_out     (out_last_out)
  );

endmodule

@@ sv/dqf_pack.sv @@
module dqf_pack (
  input  logic           clk,
  input  logic           rst_n,
  input  dqf_pkg::s3_t   s3_r,
  output logic           out_valid,
  output logic [31:0]    out_value_bits,
  output logic           out_format_error,
  output logic           out_last_out
);

  logic [31:0]       val_nxt;
  logic [24:0]       q;
  logic              rnd;
  logic signed [9:0] er;
  logic [31:0]       den;
  logic              valid_r;
  logic [31:0]       val_r;
  logic              err_r;
  logic              last_r;

  always_comb begin
    rnd = s3_r.norm[7] & ((|s3_r.norm[6:0]) | s3_r.norm[8]);
    q   = {1'b0, s3_r.norm[31:8]} + {24'd0, rnd};
    er  = s3_r.e + (q[24] ? 10'sd1 : 10'sd0);
    den = s3_r.prod << s3_r.k;
    if (s3_r.spec) begin
      val_nxt = s3_r.spec_val;
    end else if (s3_r.zero) begin
      val_nxt = {s3_r.sign, 31'd0};
    end else if (s3_r.e >= 10'sd1) begin
      if (er >= 10'sd255) begin
        val_nxt = {s3_r.sign, 8'hFF, 23'd0};
      end else if (q[24]) begin
        val_nxt = {s3_r.sign, er[7:0], 23'd0};
      end else begin
        val_nxt = {s3_r.sign, er[7:0], q[22:0]};
      end
    end else begin
      val_nxt = {s3_r.sign, 8'd0, den[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= s3_r.valid;
    end
    val_r  <= val_nxt;
    err_r  <= s3_r.err;
    last_r <= s3_r.last;
  end

  assign out_valid        = valid_r;
  assign out_value_bits   = val_r;
  assign out_format_error = err_r;
  assign out_last_out     = last_r;

endmodule

@@ sv/dqf_checker.sv @@
module dqf_assertions (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [31:0] out_value_bits,
  input logic        out_format_error
);

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##4 out_valid)
    else $error("transfer not answered after four cycles");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 4))
    else $error("result without a matching transfer");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_format_error) |-> (out_value_bits == 32'd0))
    else $error("format error with nonzero value");

endmodule

bind dequantize_to_float32 dqf_assertions u_dqf_assertions (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_value_bits   (out_value_bits),
  .out_format_error (out_format_error)
);
